FILE: rtl/core/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// shared types and codes for the i2c eeprom master core
// ----------------------------------------------------------------------------
package i2cee_pkg;

    // item kind codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam int unsigned DEV_ADDR_W = 7;
    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'h50;

    // apb register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [0:0] REG_DEVICE_ADDRESS = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic [7:0] byte_count;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
    } t_out_item;

endpackage

FILE: rtl/core/i2cee_seq.sv
// ----------------------------------------------------------------------------
// i2cee_seq
// bus sequencer: one delay period per tick, result formed in the same pass
// ----------------------------------------------------------------------------
module i2cee_seq
    import i2cee_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_in_item              i_item,
    input  logic [DEV_ADDR_W-1:0] i_dev_addr,
    output t_out_item             o_result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_TXL, PH_TXH, PH_TAL, PH_TAH,
        PH_RXL, PH_RXH, PH_RAL, PH_RAH, PH_P1, PH_P2, PH_P3
    } t_phase;

    typedef enum logic [2:0] {
        ST_POLL, ST_MEM, ST_DATA, ST_RADDR, ST_READ, ST_FINAL, ST_POLLSTOP
    } t_stage;

    t_phase     r_phase, n_phase;
    t_stage     r_stage, n_stage;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_pend, n_pend;
    logic [7:0] r_left, n_left;
    logic       r_is_read, n_is_read;
    logic [1:0] r_lines, n_lines;   // bit 1 scl, bit 0 sda

    logic       last;
    logic       tx_bit;
    logic [7:0] rx_data;
    logic       rx_valid;

    assign last   = (r_left <= 8'd1);
    assign tx_bit = r_shift[r_bit];

    always_comb begin
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_addr    = r_addr;
        n_pend    = r_pend;
        n_left    = r_left;
        n_is_read = r_is_read;
        n_lines   = r_lines;
        rx_data   = 8'd0;
        rx_valid  = 1'b0;

        if (i_step && i_item.kind == KIND_TICK && r_phase != PH_IDLE) begin
            unique case (r_phase)
                PH_S1: begin
                    n_lines = 2'b11;
                    n_phase = PH_S2;
                end
                PH_S2: begin
                    n_lines = 2'b10;
                    n_shift = {i_dev_addr, (r_stage == ST_RADDR)};
                    n_bit   = 3'd7;
                    n_phase = PH_TXL;
                end
                PH_TXL: begin
                    n_lines = {1'b0, tx_bit};
                    n_phase = PH_TXH;
                end
                PH_TXH: begin
                    n_lines = {1'b1, tx_bit};
                    if (r_bit == 3'd0) begin
                        n_phase = PH_TAL;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_phase = PH_TXL;
                    end
                end
                PH_TAL: begin
                    n_lines = 2'b01;
                    n_phase = PH_TAH;
                end
                PH_TAH: begin
                    n_lines = 2'b11;
                    if (r_stage == ST_POLL) begin
                        if (!i_item.sda_in) begin
                            n_stage = ST_MEM;
                            n_shift = r_addr;
                            n_bit   = 3'd7;
                            n_phase = PH_TXL;
                        end else begin
                            n_stage = ST_POLLSTOP;
                            n_phase = PH_P1;
                        end
                    end else if (r_stage == ST_MEM) begin
                        if (r_is_read) begin
                            n_stage = ST_RADDR;
                            n_phase = PH_S1;
                        end else begin
                            n_stage = ST_DATA;
                            n_shift = r_pend;
                            n_bit   = 3'd7;
                            n_phase = PH_TXL;
                        end
                    end else if (r_stage == ST_RADDR) begin
                        n_stage = ST_READ;
                        n_shift = 8'd0;
                        n_bit   = 3'd7;
                        n_phase = PH_RXL;
                    end else begin
                        n_stage = ST_FINAL;
                        n_phase = PH_P1;
                    end
                end
                PH_RXL: begin
                    n_lines = 2'b01;
                    n_phase = PH_RXH;
                end
                PH_RXH: begin
                    n_lines        = 2'b11;
                    n_shift[r_bit] = i_item.sda_in;
                    if (r_bit == 3'd0) begin
                        rx_data  = n_shift;
                        rx_valid = 1'b1;
                        n_phase  = PH_RAL;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_phase = PH_RXL;
                    end
                end
                PH_RAL: begin
                    n_lines = {1'b0, last};
                    n_phase = PH_RAH;
                end
                PH_RAH: begin
                    n_lines = {1'b1, last};
                    if (last) begin
                        n_stage = ST_FINAL;
                        n_phase = PH_P1;
                    end else begin
                        n_left  = r_left - 8'd1;
                        n_bit   = 3'd7;
                        n_phase = PH_RXL;
                    end
                end
                PH_P1: begin
                    n_lines = 2'b00;
                    n_phase = PH_P2;
                end
                PH_P2: begin
                    n_lines = 2'b10;
                    n_phase = PH_P3;
                end
                PH_P3: begin
                    n_lines = 2'b11;
                    n_stage = ST_POLL;
                    n_phase = (r_stage == ST_POLLSTOP) ? PH_S1 : PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (i_step && r_phase == PH_IDLE &&
                     (i_item.kind == KIND_READ || i_item.kind == KIND_WRITE)) begin
            n_is_read = (i_item.kind == KIND_READ);
            n_addr    = i_item.mem_address;
            if (i_item.kind == KIND_READ) begin
                n_left = i_item.byte_count;
            end else begin
                n_pend = i_item.write_data;
            end
            n_stage = ST_POLL;
            n_phase = PH_S1;
        end
    end

    always_comb begin
        o_result.scl_out    = n_lines[1];
        o_result.sda_out    = n_lines[0];
        o_result.read_data  = rx_data;
        o_result.read_valid = rx_valid;
        o_result.read_last  = rx_valid & last;
        o_result.busy_res   = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_stage   <= ST_POLL;
            r_bit     <= 3'd0;
            r_shift   <= 8'd0;
            r_addr    <= 8'd0;
            r_pend    <= 8'd0;
            r_left    <= 8'd0;
            r_is_read <= 1'b0;
            r_lines   <= 2'b11;
        end else begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_addr    <= n_addr;
            r_pend    <= n_pend;
            r_left    <= n_left;
            r_is_read <= n_is_read;
            r_lines   <= n_lines;
        end
    end

endmodule

FILE: rtl/core/i2c_eeprom_master_core.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_master_core
// i2c master for a small serial eeprom, stepped one bus delay period per tick item
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) carries ticks and
//   read or write requests. a tick advances the bus sequencer by one delay
//   period and samples sda; a request starts a transaction when idle and is
//   dropped while busy.
//   output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result per transfer: scl and sda levels, a received byte with its
//   valid and last flags, and the busy flag.
//   each result is registered in the cycle after its input transfer; one item
//   can be taken every cycle, limited only by the single result register.
//   when the receiver stalls, the result register holds and the input side
//   stalls only while that register is full and not being drained.
//   reset clears the sequencer to idle with both lines released high and
//   the device address back to 0x50.
//   the device address register sits at apb byte address 0; configure it
//   only while the core is idle.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_core
    import i2cee_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [DEV_ADDR_W-1:0] r_dev_addr;
    logic                  r_out_valid;
    t_out_item             r_out_data;
    t_out_item             seq_result;
    logic                  in_xfer;
    logic                  reg_sel;

    // register index from the word address
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_DEVICE_ADDRESS);

    assign pready = 1'b1;
    assign prdata = reg_sel ? {{(32-DEV_ADDR_W){1'b0}}, r_dev_addr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_dev_addr <= pwdata[DEV_ADDR_W-1:0];
        end
    end

    // take a new item whenever the result slot is free or draining
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    i2cee_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (in_xfer),
        .i_item     (i_in_data),
        .i_dev_addr (r_dev_addr),
        .o_result   (seq_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= seq_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
